@@ rtl/core/rrv_pkg.sv @@
package rrv_pkg;

   typedef logic [11:0] pos_type;
   typedef logic [7:0]  chan_type;
   typedef logic [2:0]  csr_idx_type;
   typedef logic [15:0] csr_data_type;

   localparam logic [12:0] MaxDim = 13'd4096;

   // register indexes
   localparam csr_idx_type RegStrength  = 3'd0;
   localparam csr_idx_type RegEdgeFracX = 3'd1;
   localparam csr_idx_type RegEdgeFracY = 3'd2;
   localparam csr_idx_type RegRadius    = 3'd3;
   localparam csr_idx_type RegFalloff   = 3'd4;
   localparam csr_idx_type RegWidth     = 3'd5;
   localparam csr_idx_type RegHeight    = 3'd6;

   // reset values, and the defaults a zero register selects (frame sizes: reset only, zero clamps to 1)
   localparam logic [15:0] StrengthDef = 16'd32768;
   localparam logic [15:0] EdgeFracDef = 16'd6554;
   localparam logic [11:0] RadiusDef   = 12'd50;
   localparam logic [15:0] FalloffDef  = 16'd8192;
   localparam logic [12:0] FrameDef    = 13'd1024;

   // stage numbering
   localparam int StIn       = 0;
   localparam int StDist     = 1;
   localparam int StSetup    = 2;
   localparam int StSum      = 3;
   localparam int DivEFirst  = 3;
   localparam int DivELast   = 19;
   localparam int SqrtFirst  = 4;
   localparam int SqrtLast   = 31;
   localparam int StMin      = 20;
   localparam int StLz       = 21;
   localparam int SqFirst    = 22;
   localparam int SqLast     = 37;
   localparam int StLg       = 38;
   localparam int StPow      = 39;
   localparam int StExpSet   = 40;
   localparam int ExpFirst   = 41;
   localparam int ExpLast    = 56;
   localparam int StPw       = 57;
   localparam int StBlendMul = 58;
   localparam int StBlend    = 59;
   localparam int StCnum     = 32;
   localparam int DivCFirst  = 33;
   localparam int DivCLast   = 49;
   localparam int StCorner   = 50;
   localparam int StMaskMul  = 60;
   localparam int StOut      = 61;
   localparam int NumStages  = 62;

   // 2^(2^-(i+1)) in Q16
   localparam logic [16:0] Exp2Tab [16] = '{
      17'd92682, 17'd77936, 17'd71468, 17'd68438, 17'd66971, 17'd66250, 17'd65892, 17'd65714,
      17'd65625, 17'd65580, 17'd65558, 17'd65547, 17'd65542, 17'd65539, 17'd65537, 17'd65537
   };

   typedef struct packed {
      chan_type    red;
      chan_type    green;
      chan_type    blue;
      pos_type     pos_x;
      pos_type     pos_y;
      logic [10:0] ed_x;
      logic [10:0] ed_y;
      logic [12:0] bd_x;
      logic [12:0] bd_y;
      logic        ov_x;
      logic        ov_y;
      logic [44:0] rem_x;
      logic [44:0] rem_y;
      logic [16:0] quo_x;
      logic [16:0] quo_y;
      logic [25:0] sq_x;
      logic [25:0] sq_y;
      logic [26:0] d2;
      logic        far;
      logic [55:0] srem;
      logic [27:0] root;
      logic [16:0] m;
      logic        m_zero;
      logic        m_one;
      logic [4:0]  lg_int;
      logic [15:0] nrm;
      logic [15:0] frac;
      logic [20:0] lg;
      logic [8:0]  ip;
      logic [15:0] fp;
      logic        spec;
      logic [16:0] spec_val;
      logic [15:0] gexp;
      logic [17:0] eq;
      logic [16:0] pw;
      logic [33:0] bprod;
      logic [16:0] blend;
      logic [28:0] crem;
      logic [16:0] cquo;
      logic [16:0] corner;
      logic [33:0] mprod;
   } pix_type;

endpackage

@@ rtl/core/rrv_req_if.sv @@
interface rrv_req_if;
   logic              valid;
   logic              ready;
   rrv_pkg::pos_type  pos_x;
   rrv_pkg::pos_type  pos_y;
   rrv_pkg::chan_type in_red;
   rrv_pkg::chan_type in_green;
   rrv_pkg::chan_type in_blue;

   modport source (output valid, pos_x, pos_y, in_red, in_green, in_blue, input ready);
   modport sink (input valid, pos_x, pos_y, in_red, in_green, in_blue, output ready);
endinterface

@@ rtl/core/rrv_rsp_if.sv @@
interface rrv_rsp_if;
   logic              valid;
   logic              ready;
   rrv_pkg::chan_type out_red;
   rrv_pkg::chan_type out_green;
   rrv_pkg::chan_type out_blue;

   modport source (output valid, out_red, out_green, out_blue, input ready);
   modport sink (input valid, out_red, out_green, out_blue, output ready);
endinterface

@@ rtl/core/rrv_csr_if.sv @@
interface rrv_csr_if;
   logic                  valid;
   logic                  ready;
   rrv_pkg::csr_idx_type  index;
   rrv_pkg::csr_data_type wdata;

   modport source (output valid, index, wdata, input ready);
   modport sink (input valid, index, wdata, output ready);
endinterface

@@ rtl/core/rounded_rect_vignette.sv @@
// rounded-rectangle vignette: scales each pixel's three color bytes by an edge/corner mask
// req_if: one pixel per beat (pos_x, pos_y, in_red, in_green, in_blue)
// rsp_if: one beat per pixel, in order (out_red, out_green, out_blue)
// csr_if: register writes, always ready; index 0..6 selects strength, edge fractions,
//   corner radius, falloff exponent, frame width, frame height; other indexes are dropped
// a pixel passes through 62 register stages, which hold the 17-step edge divide,
//   the 28-step square root and the 16-step log and exp chains
// one pixel per cycle while rsp_if does not stall; every stage moves together
// when rsp_if stalls with a beat held, the whole pipe freezes and req_if.ready drops,
//   so nothing is lost or repeated
// reset clears all valid bits and loads the register defaults
// the user must see that registers are changed only while no pixel is in flight; the block does not enforce this
module rounded_rect_vignette (
   input  logic       clock,
   input  logic       reset,
   rrv_req_if.sink    req_if,
   rrv_rsp_if.source  rsp_if,
   rrv_csr_if.sink    csr_if
);

   localparam int Last = rrv_pkg::NumStages - 1;

   logic [15:0] strength_ff, frac_x_ff, frac_y_ff, falloff_ff;
   logic [11:0] radius_ff;
   logic [12:0] width_ff, height_ff;
   logic [15:0] s_eff, fx_eff, fy_eff, e_eff;
   logic [11:0] rad_eff;
   logic [12:0] w_eff, h_eff;
   logic [27:0] den_x_ff, den_y_ff;
   logic [23:0] rad2_ff;

   rrv_pkg::pix_type pipe_ff [rrv_pkg::NumStages];
   rrv_pkg::pix_type pipe_in [rrv_pkg::NumStages];
   logic [Last:0] vld_ff, vld_in;
   logic adv;

   function automatic logic [12:0] clamp_dim(logic [12:0] v);
      if (v == 13'd0) return 13'd1;
      else if (v > rrv_pkg::MaxDim) return rrv_pkg::MaxDim;
      else return v;
   endfunction

   function automatic logic [10:0] edge_dist(logic [11:0] pos, logic [12:0] size);
      logic [12:0] p13, mir;
      p13 = {1'b0, pos};
      mir = size - 13'd1 - p13;
      if (p13 >= size) return 11'd0;
      else if (p13 < mir) return p13[10:0];
      else return mir[10:0];
   endfunction

   // signed on purpose: a radius above half the frame makes the bands overlap
   function automatic logic [12:0] band_dist(logic [11:0] pos, logic [12:0] size,
                                             logic [11:0] rad);
      logic signed [14:0] sp, ss, sr, lim, res;
      sp  = signed'({3'b0, pos});
      ss  = signed'({2'b0, size});
      sr  = signed'({3'b0, rad});
      lim = ss - sr;
      if (sp < sr) res = sr - sp;
      else if (sp >= lim) res = sp - lim + 15'sd1;
      else res = 15'sd0;
      return res[12:0];
   endfunction

   // register file
   assign csr_if.ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         strength_ff <= rrv_pkg::StrengthDef;
         frac_x_ff   <= rrv_pkg::EdgeFracDef;
         frac_y_ff   <= rrv_pkg::EdgeFracDef;
         radius_ff   <= rrv_pkg::RadiusDef;
         falloff_ff  <= rrv_pkg::FalloffDef;
         width_ff    <= rrv_pkg::FrameDef;
         height_ff   <= rrv_pkg::FrameDef;
      end else if (csr_if.valid) begin
         unique case (csr_if.index)
            rrv_pkg::RegStrength:  strength_ff <= csr_if.wdata;
            rrv_pkg::RegEdgeFracX: frac_x_ff   <= csr_if.wdata;
            rrv_pkg::RegEdgeFracY: frac_y_ff   <= csr_if.wdata;
            rrv_pkg::RegRadius:    radius_ff   <= csr_if.wdata[11:0];
            rrv_pkg::RegFalloff:   falloff_ff  <= csr_if.wdata;
            rrv_pkg::RegWidth:     width_ff    <= csr_if.wdata[12:0];
            rrv_pkg::RegHeight:    height_ff   <= csr_if.wdata[12:0];
            default: ;
         endcase
      end
   end

   always_comb begin
      s_eff   = (strength_ff == 16'd0) ? rrv_pkg::StrengthDef : strength_ff;
      fx_eff  = (frac_x_ff == 16'd0) ? rrv_pkg::EdgeFracDef : frac_x_ff;
      fy_eff  = (frac_y_ff == 16'd0) ? rrv_pkg::EdgeFracDef : frac_y_ff;
      rad_eff = (radius_ff == 12'd0) ? rrv_pkg::RadiusDef : radius_ff;
      e_eff   = (falloff_ff == 16'd0) ? rrv_pkg::FalloffDef : falloff_ff;
      w_eff   = clamp_dim(width_ff);
      h_eff   = clamp_dim(height_ff);
   end

   // divisors and squared radius, stable while pixels flow
   always_ff @(posedge clock) begin
      den_x_ff <= 28'(29'(w_eff) * 29'(fx_eff));
      den_y_ff <= 28'(29'(h_eff) * 29'(fy_eff));
      rad2_ff  <= 24'(rad_eff) * 24'(rad_eff);
   end

   // pipeline control: all stages step together
   assign adv          = !vld_ff[Last] || rsp_if.ready;
   assign req_if.ready = adv;
   assign vld_in       = {vld_ff[Last-1:0], req_if.valid};

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff <= '0;
      end else if (adv) begin
         vld_ff <= vld_in;
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         pipe_ff <= pipe_in;
      end
   end

   always_comb begin
      pipe_in[rrv_pkg::StIn]       = '0;
      pipe_in[rrv_pkg::StIn].pos_x = req_if.pos_x;
      pipe_in[rrv_pkg::StIn].pos_y = req_if.pos_y;
      pipe_in[rrv_pkg::StIn].red   = req_if.in_red;
      pipe_in[rrv_pkg::StIn].green = req_if.in_green;
      pipe_in[rrv_pkg::StIn].blue  = req_if.in_blue;
   end

   for (genvar s = 1; s < rrv_pkg::NumStages; s++) begin : g_stage
      localparam int JE = (s >= rrv_pkg::DivEFirst && s <= rrv_pkg::DivELast) ?
                          rrv_pkg::DivELast - s : 0;
      localparam int IS = (s >= rrv_pkg::SqrtFirst && s <= rrv_pkg::SqrtLast) ?
                          rrv_pkg::SqrtLast - s : 0;
      localparam int JC = (s >= rrv_pkg::DivCFirst && s <= rrv_pkg::DivCLast) ?
                          rrv_pkg::DivCLast - s : 0;
      localparam int IE = (s >= rrv_pkg::ExpFirst && s <= rrv_pkg::ExpLast) ?
                          s - rrv_pkg::ExpFirst : 0;

      rrv_pkg::pix_type prv;
      logic [44:0] dsh_x, dsh_y;
      logic [55:0] base_rem;
      logic [27:0] base_root;
      logic [57:0] trial;
      logic [3:0]  k;
      logic [31:0] sqp;
      logic [16:0] n2;
      logic [36:0] lge;
      logic [34:0] eprod;
      logic [28:0] rsh;
      logic [24:0] pr, pg, pb;

      always_comb begin
         prv       = pipe_ff[s-1];
         dsh_x     = '0;
         dsh_y     = '0;
         base_rem  = '0;
         base_root = '0;
         trial     = '0;
         k         = '0;
         sqp       = '0;
         n2        = '0;
         lge       = '0;
         eprod     = '0;
         rsh       = '0;
         pr        = '0;
         pg        = '0;
         pb        = '0;
         pipe_in[s] = prv;

         if (s == rrv_pkg::StDist) begin
            pipe_in[s].ed_x = edge_dist(prv.pos_x, w_eff);
            pipe_in[s].ed_y = edge_dist(prv.pos_y, h_eff);
            pipe_in[s].bd_x = band_dist(prv.pos_x, w_eff, rad_eff);
            pipe_in[s].bd_y = band_dist(prv.pos_y, h_eff, rad_eff);
         end

         if (s == rrv_pkg::StSetup) begin
            // quotient would reach 2^17: flag it for the clamp at StMin
            pipe_in[s].ov_x  = {2'b0, prv.ed_x, 15'b0} >= den_x_ff;
            pipe_in[s].ov_y  = {2'b0, prv.ed_y, 15'b0} >= den_y_ff;
            pipe_in[s].rem_x = {2'b0, prv.ed_x, 32'b0};
            pipe_in[s].rem_y = {2'b0, prv.ed_y, 32'b0};
            pipe_in[s].quo_x = '0;
            pipe_in[s].quo_y = '0;
            pipe_in[s].sq_x  = 26'(prv.bd_x) * 26'(prv.bd_x);
            pipe_in[s].sq_y  = 26'(prv.bd_y) * 26'(prv.bd_y);
         end

         if (s == rrv_pkg::StSum) begin
            pipe_in[s].d2  = {1'b0, prv.sq_x} + {1'b0, prv.sq_y};
            pipe_in[s].far = ({1'b0, prv.sq_x} + {1'b0, prv.sq_y}) >= {3'b0, rad2_ff};
         end

         if (s >= rrv_pkg::DivEFirst && s <= rrv_pkg::DivELast) begin
            dsh_x = {17'b0, den_x_ff} << JE;
            dsh_y = {17'b0, den_y_ff} << JE;
            if (prv.rem_x >= dsh_x) begin
               pipe_in[s].rem_x     = prv.rem_x - dsh_x;
               pipe_in[s].quo_x[JE] = 1'b1;
            end
            if (prv.rem_y >= dsh_y) begin
               pipe_in[s].rem_y     = prv.rem_y - dsh_y;
               pipe_in[s].quo_y[JE] = 1'b1;
            end
         end

         if (s >= rrv_pkg::SqrtFirst && s <= rrv_pkg::SqrtLast) begin
            base_rem  = (s == rrv_pkg::SqrtFirst) ? {prv.d2[23:0], 32'b0} : prv.srem;
            base_root = (s == rrv_pkg::SqrtFirst) ? 28'd0 : prv.root;
            // (2*root + 2^i) * 2^i is the growth of root^2 when bit i is set
            trial = ((58'(base_root) << 1) | (58'd1 << IS)) << IS;
            pipe_in[s].srem = base_rem;
            pipe_in[s].root = base_root;
            if ({2'b0, base_rem} >= trial) begin
               pipe_in[s].srem = base_rem - trial[55:0];
               pipe_in[s].root = base_root | (28'd1 << IS);
            end
         end

         if (s == rrv_pkg::StMin) begin
            logic [16:0] nx, ny;
            nx = (prv.ov_x || prv.quo_x > 17'h10000) ? 17'h10000 : prv.quo_x;
            ny = (prv.ov_y || prv.quo_y > 17'h10000) ? 17'h10000 : prv.quo_y;
            pipe_in[s].m = (nx < ny) ? nx : ny;
         end

         if (s == rrv_pkg::StLz) begin
            for (int b = 0; b < 16; b++) begin
               if (prv.m[b]) k = 4'(b);
            end
            pipe_in[s].m_one  = prv.m[16];
            pipe_in[s].m_zero = (prv.m == 17'd0);
            pipe_in[s].nrm    = prv.m[15:0] << (4'd15 - k);
            pipe_in[s].lg_int = 5'd16 - {1'b0, k};
            pipe_in[s].frac   = '0;
         end

         if (s >= rrv_pkg::SqFirst && s <= rrv_pkg::SqLast) begin
            // one log2 fraction bit per squaring
            sqp = 32'(prv.nrm) * 32'(prv.nrm);
            n2  = sqp[31:15];
            pipe_in[s].frac = {prv.frac[14:0], n2[16]};
            pipe_in[s].nrm  = n2[16] ? n2[16:1] : n2[15:0];
         end

         if (s == rrv_pkg::StLg) begin
            pipe_in[s].lg = {prv.lg_int, 16'b0} - {5'b0, prv.frac};
         end

         if (s == rrv_pkg::StPow) begin
            lge = 37'(prv.lg) * 37'(e_eff);
            pipe_in[s].ip = lge[36:28];
            pipe_in[s].fp = lge[27:12];
         end

         if (s == rrv_pkg::StExpSet) begin
            pipe_in[s].gexp     = 16'd0 - prv.fp;
            pipe_in[s].eq       = 18'h10000;
            pipe_in[s].spec     = 1'b1;
            pipe_in[s].spec_val = '0;
            if (prv.m_one) pipe_in[s].spec_val = 17'h10000;
            else if (prv.m_zero || prv.ip >= 9'd20) pipe_in[s].spec_val = '0;
            else if (prv.fp == 16'd0) pipe_in[s].spec_val = 17'h10000 >> prv.ip;
            else pipe_in[s].spec = 1'b0;
         end

         if (s >= rrv_pkg::ExpFirst && s <= rrv_pkg::ExpLast) begin
            eprod = 35'(prv.eq) * 35'(rrv_pkg::Exp2Tab[IE]);
            if (prv.gexp[15-IE]) pipe_in[s].eq = eprod[33:16];
         end

         if (s == rrv_pkg::StPw) begin
            pipe_in[s].pw = prv.spec ? prv.spec_val : 17'((prv.eq >> prv.ip) >> 1);
         end

         if (s == rrv_pkg::StBlendMul) begin
            pipe_in[s].bprod = 34'(prv.pw) * 34'(17'h10000 - {1'b0, s_eff});
         end

         if (s == rrv_pkg::StBlend) begin
            pipe_in[s].blend = 17'(18'(prv.bprod[33:16]) + 18'(s_eff));
         end

         if (s == rrv_pkg::StCnum) begin
            pipe_in[s].crem = {1'b0, rad_eff, 16'b0} - {1'b0, prv.root};
            pipe_in[s].cquo = '0;
         end

         if (s >= rrv_pkg::DivCFirst && s <= rrv_pkg::DivCLast) begin
            rsh = {17'b0, rad_eff} << JC;
            if (prv.crem >= rsh) begin
               pipe_in[s].crem     = prv.crem - rsh;
               pipe_in[s].cquo[JC] = 1'b1;
            end
         end

         if (s == rrv_pkg::StCorner) begin
            pipe_in[s].corner = prv.far ? 17'd0 : prv.cquo;
         end

         if (s == rrv_pkg::StMaskMul) begin
            pipe_in[s].mprod = 34'(prv.blend) * 34'(prv.corner);
         end

         if (s == rrv_pkg::StOut) begin
            pr = 25'(prv.red) * 25'(prv.mprod[32:16]);
            pg = 25'(prv.green) * 25'(prv.mprod[32:16]);
            pb = 25'(prv.blue) * 25'(prv.mprod[32:16]);
            pipe_in[s].red   = pr[23:16];
            pipe_in[s].green = pg[23:16];
            pipe_in[s].blue  = pb[23:16];
         end
      end
   end

   assign rsp_if.valid     = vld_ff[Last];
   assign rsp_if.out_red   = pipe_ff[Last].red;
   assign rsp_if.out_green = pipe_ff[Last].green;
   assign rsp_if.out_blue  = pipe_ff[Last].blue;

endmodule
